FILE: hw/rtl/smartcard_app_directory_core_assert.svh
// Assertion macros for the application directory core.
// Used by modules that include this header; expects i_clk and i_rst_n in scope.
`ifndef SMARTCARD_APP_DIRECTORY_CORE_ASSERT_SVH
`define SMARTCARD_APP_DIRECTORY_CORE_ASSERT_SVH

// condition holds at every edge outside reset
`define SCAD_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define SCAD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCAD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/scad_pkg.sv
// Shared types and constants of the application directory core.
// No dependencies.
package scad_pkg;

    localparam int SLOTS      = 28;
    localparam int MAX_KEYS   = 14;
    localparam int FRAME_AIDS = 19;
    localparam int FRAME_CAP  = (FRAME_AIDS > 20) ? 20 : FRAME_AIDS;
    localparam int QDEPTH     = 2;

    localparam int AID_W  = 24;
    localparam int SLOT_W = 5;
    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int ADR_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(FRAME_CAP + 1);

    localparam logic [2:0] KIND_SELECT     = 3'd0;
    localparam logic [2:0] KIND_CREATE     = 3'd1;
    localparam logic [2:0] KIND_DELETE     = 3'd2;
    localparam logic [2:0] KIND_LIST_FIRST = 3'd3;
    localparam logic [2:0] KIND_LIST_NEXT  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_KEYS       = 3'd4;
    localparam logic [2:0] ST_NO_STORAGE = 3'd5;
    localparam logic [2:0] ST_MORE       = 3'd6;

    typedef enum logic [2:0] {
        OP_SELECT,
        OP_CREATE,
        OP_DELETE,
        OP_LIST_FIRST,
        OP_LIST_NEXT,
        OP_BAD
    } t_op;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOOK,
        B_FREE,
        B_CNT,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        logic [2:0]       kind;
        logic [AID_W-1:0] aid;
        logic [7:0]       key_count;
        logic [7:0]       key_settings;
        logic [7:0]       storage_block;
    } t_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [AID_W-1:0]  listed_aid;
        logic              aid_valid;
        logic [SLOT_W-1:0] selected_slot;
        logic              last;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic [AID_W-1:0] aid;
        logic [7:0]       settings;
        logic [7:0]       block;
        logic             keys_over;
        logic             no_block;
    } t_cmd;

    typedef struct packed {
        logic [AID_W-1:0] aid;
        logic [7:0]       storage;
        logic [7:0]       settings;
    } t_entry;

endpackage

FILE: hw/rtl/scad_front.sv
// Front end: takes command transfers and classifies them for the back end.
// Depends on scad_pkg.
module scad_front (
    input  logic          i_start,
    input  scad_pkg::t_item i_item,
    input  logic          i_full,
    output logic          o_busy,
    output logic          o_push,
    output scad_pkg::t_cmd  o_cmd
);
    import scad_pkg::*;

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_cmd.aid       = i_item.aid;
        o_cmd.settings  = i_item.key_settings;
        o_cmd.block     = i_item.storage_block;
        o_cmd.keys_over = (i_item.key_count > 8'(MAX_KEYS));
        o_cmd.no_block  = (i_item.storage_block == 8'd0);
        case (i_item.kind)
            KIND_SELECT:     o_cmd.op = OP_SELECT;
            KIND_CREATE:     o_cmd.op = OP_CREATE;
            KIND_DELETE:     o_cmd.op = OP_DELETE;
            KIND_LIST_FIRST: o_cmd.op = OP_LIST_FIRST;
            KIND_LIST_NEXT:  o_cmd.op = OP_LIST_NEXT;
            default:         o_cmd.op = OP_BAD;
        endcase
    end

endmodule

FILE: hw/rtl/scad_fifo.sv
// Short command queue between front and back end.
// Depends on scad_pkg.
module scad_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scad_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output scad_pkg::t_cmd o_cmd,
    output logic           o_vld,
    output logic           o_full
);
    import scad_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W  = $clog2(QDEPTH + 1);

    t_cmd             r_q [QDEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0]  r_cnt, n_cnt;

    assign o_vld  = (r_cnt != '0);
    assign o_full = (r_cnt == QC_W'(QDEPTH));
    assign o_cmd  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/scad_back.sv
// Back end: directory table, slot scanner and result register.
// Depends on scad_pkg and smartcard_app_directory_core_assert.svh.
module scad_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scad_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_vld,
    output logic              o_pop,
    output scad_pkg::t_result o_result,
    output logic              o_strobe
);
    import scad_pkg::*;
    `include "smartcard_app_directory_core_assert.svh"

    t_entry           r_mem [SLOTS];
    logic             r_vld [SLOTS];

    t_bstate          r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_start, n_start;
    logic [IDX_W-1:0] r_first_free, n_first_free;
    logic [ADR_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0] r_resume, n_resume;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_emit, n_emit;
    logic             r_more, n_more;
    logic             r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    t_entry           r_rd_ent;
    logic             r_rd_ok;
    t_result          r_out, n_out;
    logic             r_strobe, n_strobe;

    logic             wr_en, clr_en;
    logic [ADR_W-1:0] wr_adr, clr_adr;
    logic [ADR_W-1:0] rd_adr;
    logic [AID_W-1:0] rd_aid, key;
    logic             inv, scanning, rd_hit, scan_end, look_done;
    logic             cnt_stop, cnt_done, emit_last, stop, issue, cre_go;
    logic [CNT_W-1:0] emit_inc;

    function automatic t_result mk_res(input logic [2:0] st, input logic [IDX_W-1:0] sl,
                                       input logic [AID_W-1:0] a, input logic v,
                                       input logic [ADR_W-1:0] sel, input logic lst);
        t_result r;
        r.status        = st;
        r.slot          = SLOT_W'(sl);
        r.listed_aid    = a;
        r.aid_valid     = v;
        r.selected_slot = SLOT_W'(sel);
        r.last          = lst;
        return r;
    endfunction

    assign o_result = r_out;
    assign o_strobe = r_strobe;

    assign rd_adr   = r_idx[ADR_W-1:0];
    assign rd_aid   = r_rd_ok ? r_rd_ent.aid : '0;
    assign key      = (r_state == B_LOOK) ? r_cmd.aid : '0;
    assign inv      = (r_state == B_CNT) || (r_state == B_EMIT);
    assign scanning = (r_state != B_IDLE);
    assign rd_hit   = r_rd_vld && (inv ? (rd_aid != '0) : (rd_aid == key));
    assign scan_end = (r_idx == IDX_W'(SLOTS)) && !r_rd_vld;
    assign look_done = rd_hit || scan_end;
    assign cnt_stop = rd_hit && (r_cnt == CNT_W'(FRAME_CAP));
    assign cnt_done = cnt_stop || scan_end;
    assign emit_inc = r_emit + CNT_W'(1);
    assign emit_last = rd_hit && (emit_inc == r_cnt);
    assign cre_go   = (r_cmd.op == OP_CREATE) && !rd_hit
                      && (r_first_free < IDX_W'(SLOTS))
                      && !r_cmd.keys_over && !r_cmd.no_block;

    always_comb begin
        case (r_state)
            B_LOOK:  stop = look_done;
            B_FREE:  stop = look_done;
            B_CNT:   stop = cnt_done;
            B_EMIT:  stop = emit_last || scan_end;
            default: stop = 1'b0;
        endcase
    end

    assign issue = scanning && !stop && (r_idx < IDX_W'(SLOTS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_vld) begin
                    case (i_cmd.op)
                        OP_SELECT, OP_CREATE, OP_DELETE: n_state = B_LOOK;
                        OP_LIST_FIRST, OP_LIST_NEXT:     n_state = B_CNT;
                        default:                         n_state = B_IDLE;
                    endcase
                end
            end
            B_LOOK: begin
                if (look_done) begin
                    n_state = cre_go ? B_FREE : B_IDLE;
                end
            end
            B_FREE: begin
                if (look_done) begin
                    n_state = B_IDLE;
                end
            end
            B_CNT: begin
                if (cnt_done) begin
                    n_state = (r_cnt == '0) ? B_IDLE : B_EMIT;
                end
            end
            B_EMIT: begin
                if (emit_last || scan_end) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_pop        = 1'b0;
        n_cmd        = r_cmd;
        n_idx        = issue ? r_idx + IDX_W'(1) : r_idx;
        n_start      = r_start;
        n_first_free = r_first_free;
        n_cur        = r_cur;
        n_resume     = r_resume;
        n_cnt        = r_cnt;
        n_emit       = r_emit;
        n_more       = r_more;
        n_rd_vld     = issue;
        n_out        = r_out;
        n_strobe     = 1'b0;
        wr_en        = 1'b0;
        wr_adr       = r_first_free[ADR_W-1:0];
        clr_en       = 1'b0;
        clr_adr      = r_rd_idx[ADR_W-1:0];
        case (r_state)
            B_IDLE: begin
                if (i_cmd_vld) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_cmd;
                    n_cnt  = '0;
                    n_more = 1'b0;
                    case (i_cmd.op)
                        OP_SELECT, OP_CREATE, OP_DELETE: n_idx = '0;
                        OP_LIST_FIRST: begin
                            n_resume = IDX_W'(1);
                            n_start  = IDX_W'(1);
                            n_idx    = IDX_W'(1);
                        end
                        OP_LIST_NEXT: begin
                            n_start = r_resume;
                            n_idx   = r_resume;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_out = mk_res(ST_NOT_FOUND, IDX_W'(SLOTS), '0, 1'b0, r_cur, 1'b1);
                        end
                    endcase
                end
            end
            B_LOOK: begin
                if (look_done) begin
                    n_strobe = 1'b1;
                    case (r_cmd.op)
                        OP_SELECT: begin
                            if (rd_hit) begin
                                n_cur = r_rd_idx[ADR_W-1:0];
                                n_out = mk_res(ST_OK, r_rd_idx, '0, 1'b0, n_cur, 1'b1);
                            end else begin
                                n_out = mk_res(ST_NOT_FOUND, IDX_W'(SLOTS), '0, 1'b0,
                                               r_cur, 1'b1);
                            end
                        end
                        OP_DELETE: begin
                            if (rd_hit && r_rd_idx != '0) begin
                                clr_en = 1'b1;
                                if (r_rd_idx < r_first_free) begin
                                    n_first_free = r_rd_idx;
                                end
                                if (r_cur == r_rd_idx[ADR_W-1:0]) begin
                                    n_cur = '0;
                                end
                                n_out = mk_res(ST_OK, r_rd_idx, '0, 1'b0, n_cur, 1'b1);
                            end else begin
                                n_out = mk_res(ST_NOT_FOUND, IDX_W'(SLOTS), '0, 1'b0,
                                               r_cur, 1'b1);
                            end
                        end
                        OP_CREATE: begin
                            if (rd_hit) begin
                                n_out = mk_res(ST_DUPLICATE, r_rd_idx, '0, 1'b0, r_cur, 1'b1);
                            end else if (r_first_free >= IDX_W'(SLOTS)) begin
                                n_out = mk_res(ST_FULL, IDX_W'(SLOTS), '0, 1'b0, r_cur, 1'b1);
                            end else if (r_cmd.keys_over) begin
                                n_out = mk_res(ST_KEYS, IDX_W'(SLOTS), '0, 1'b0, r_cur, 1'b1);
                            end else if (r_cmd.no_block) begin
                                n_out = mk_res(ST_NO_STORAGE, IDX_W'(SLOTS), '0, 1'b0,
                                               r_cur, 1'b1);
                            end else begin
                                wr_en = 1'b1;
                                n_idx = r_first_free + IDX_W'(1);
                                n_out = mk_res(ST_OK, r_first_free, '0, 1'b0, r_cur, 1'b1);
                            end
                        end
                        default: begin
                            n_out = mk_res(ST_NOT_FOUND, IDX_W'(SLOTS), '0, 1'b0, r_cur, 1'b1);
                        end
                    endcase
                end
            end
            B_FREE: begin
                if (rd_hit) begin
                    n_first_free = r_rd_idx;
                end else if (scan_end) begin
                    n_first_free = IDX_W'(SLOTS);
                end
            end
            B_CNT: begin
                if (cnt_stop) begin
                    n_more   = 1'b1;
                    n_resume = r_rd_idx;
                end else if (rd_hit) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (scan_end) begin
                    n_resume = IDX_W'(SLOTS);
                end
                if (cnt_done) begin
                    if (r_cnt == '0) begin
                        n_strobe = 1'b1;
                        n_out = mk_res(ST_OK, IDX_W'(SLOTS), '0, 1'b0, r_cur, 1'b1);
                    end else begin
                        n_idx  = r_start;
                        n_emit = '0;
                    end
                end
            end
            B_EMIT: begin
                if (rd_hit) begin
                    n_strobe = 1'b1;
                    n_emit   = emit_inc;
                    n_out = mk_res(r_more ? ST_MORE : ST_OK, r_rd_idx, rd_aid, 1'b1,
                                   r_cur, emit_last);
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_first_free <= IDX_W'(1);
            r_cur        <= '0;
            r_resume     <= IDX_W'(1);
            r_rd_vld     <= 1'b0;
            r_strobe     <= 1'b0;
            r_idx        <= '0;
            r_start      <= '0;
            r_cnt        <= '0;
            r_emit       <= '0;
            r_more       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_free <= n_first_free;
            r_cur        <= n_cur;
            r_resume     <= n_resume;
            r_rd_vld     <= n_rd_vld;
            r_strobe     <= n_strobe;
            r_idx        <= n_idx;
            r_start      <= n_start;
            r_cnt        <= n_cnt;
            r_emit       <= n_emit;
            r_more       <= n_more;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_out    <= n_out;
        r_rd_idx <= r_idx;
    end

    // slot valid bits: a slot that is not valid reads as a free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (wr_en) begin
                r_vld[wr_adr] <= 1'b1;
            end
            if (clr_en) begin
                r_vld[clr_adr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_adr] <= '{aid: r_cmd.aid, storage: r_cmd.block, settings: r_cmd.settings};
        end
        r_rd_ent <= r_mem[rd_adr];
        r_rd_ok  <= r_vld[rd_adr];
    end

    `SCAD_ASSERT_NOW(a_first_free_nz, r_first_free != '0, "first free slot points at slot 0")
    `SCAD_ASSERT_IMP(a_list_slot, r_strobe && r_out.aid_valid,
                     (r_out.slot < SLOT_W'(SLOTS)) && (r_out.listed_aid != '0),
                     "listed result without a used slot")
    `SCAD_ASSERT_IMP(a_rd_in_scan, r_rd_vld,
                     (r_state == B_LOOK) || (r_state == B_FREE) || (r_state == B_CNT)
                     || (r_state == B_EMIT), "table read in flight outside a scan")
    `SCAD_ASSERT_NXT(a_pop_acts, o_pop, (r_state != B_IDLE) || r_strobe,
                     "command taken from queue without effect")

endmodule

FILE: hw/rtl/smartcard_app_directory_core.sv
// Top level of the application directory core: front end, queue, back end.
// Depends on scad_pkg, scad_front, scad_fifo and scad_back.
//
//  channel   ports                      transfer when
//  command   start, i_item, busy        start high and busy low at a clock edge
//  result    o_strobe, o_result         o_strobe high (one cycle, always taken)
//
// Select and delete answer when the lookup scan finds the slot or reaches the table end.
// Create answers after the lookup scan; when it wrote a slot, it then holds the back
// end for the next-free scan.
// A list frame runs a count scan, then an emit scan when the count is not zero.
// The pace is one directory table read per cycle on its single read port.
// Reset clears the slot valid bits at once; no clearing pass is needed.
// busy is high while the two-entry command queue is full; results cannot stall.
module smartcard_app_directory_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  scad_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output scad_pkg::t_result o_result
);
    import scad_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push, pop, queue_vld, queue_full;

    scad_front u_front (
        .i_start (start),
        .i_item  (i_item),
        .i_full  (queue_full),
        .o_busy  (busy),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    scad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_vld   (queue_vld),
        .o_full  (queue_full)
    );

    scad_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (queue_cmd),
        .i_cmd_vld (queue_vld),
        .o_pop     (pop),
        .o_result  (o_result),
        .o_strobe  (o_strobe)
    );

endmodule
